// ===== rtl/slu_pkg.sv =====
package slu_pkg;

	localparam int LEN_W           = 24;
	localparam int LENGTH_BITS_DEF = 24;
	localparam int QDEPTH          = 4;
	localparam int QPTR_W          = $clog2(QDEPTH);

	localparam logic [15:0] UTF8_1B_LIMIT = 16'h0080;
	localparam logic [15:0] UTF8_2B_LIMIT = 16'h0800;
	localparam logic [7:0]  UTF8_LEAD2    = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3    = 8'hE0;
	localparam logic [7:0]  UTF8_CONT     = 8'h80;
	localparam logic [7:0]  UTF8_CONT_MSK = 8'h3F;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_UNTERM   = 3'd1,
		ST_BAD_ESC  = 3'd2,
		ST_BAD_HEX  = 3'd3,
		ST_TOO_LONG = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_BODY,
		MODE_ESC,
		MODE_HEX1,
		MODE_HEX2,
		MODE_HEX3,
		MODE_HEX4
	} mode_t;

	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_CP,
		CMD_END
	} cmd_kind_t;

	// CMD_END with ST_OK: closing delimiter, too-long check done at the back
	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] val;
		status_t     status;
	} cmd_t;

endpackage

// ===== rtl/string_literal_unescaper.sv =====
// String literal unescaper.
// Input channel (in_valid/in_ready): one source byte per transaction, with
// end_of_input. The first byte while idle is the delimiter; escapes are
// decoded and \u with four hex digits comes out as 1 to 3 UTF-8 bytes.
// Output channel (out_valid/out_ready): one decoded byte per transaction
// (is_data = 1), then one final transaction with last = 1, the status and
// content_length. Errors end the literal with a single last transaction.
// cfg_wen/cfg_wdata write max_length; write only while the block is idle.
// Path: an accepted content byte is written into the command queue and then
// taken into the output register. Throughput: one input byte per cycle while
// the queue is not full; one output transaction per cycle while the queue holds
// commands and out_ready is high. A three-byte UTF-8 burst comes from a six-byte escape.
// A four-entry command queue separates the decoder from the output stage.
// When out_ready is low, the queue fills and in_ready drops once it is full.
// Reset: state idle, queue and output empty, max_length all ones.
module string_literal_unescaper
	import slu_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [LEN_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       char_byte,
	input  logic             end_of_input,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       data_byte,
	output logic             is_data,
	output logic             last,
	output logic [2:0]       status,
	output logic [LEN_W-1:0] content_length
);

	logic [LEN_W-1:0] max_length_q;
	logic             push, full, pop, empty;
	cmd_t             cmd, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_length_q <= '1;
		else if (cfg_wen)
			max_length_q <= cfg_wdata;
	end

	slu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_byte    (char_byte),
		.end_of_input (end_of_input),
		.full         (full),
		.push         (push),
		.cmd          (cmd)
	);

	slu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd),
		.full   (full),
		.pop    (pop),
		.rdata  (head),
		.empty  (empty)
	);

	slu_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.empty          (empty),
		.head           (head),
		.pop            (pop),
		.max_length     (max_length_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.data_byte      (data_byte),
		.is_data        (is_data),
		.last           (last),
		.status         (status),
		.content_length (content_length)
	);

endmodule

// ===== rtl/slu_front.sv =====
module slu_front
	import slu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_byte,
	input  logic       end_of_input,
	input  logic       full,
	output logic       push,
	output cmd_t       cmd
);

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_DQ  = 8'h22;
	localparam logic [7:0] CH_SL  = 8'h2F;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_B   = 8'h62;
	localparam logic [7:0] CH_F   = 8'h66;
	localparam logic [7:0] CH_N   = 8'h6E;
	localparam logic [7:0] CH_R   = 8'h72;
	localparam logic [7:0] CH_T   = 8'h74;
	localparam logic [7:0] CH_U   = 8'h75;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b0, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b0, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b0, 4'(c - 8'h37)};
		return r;
	endfunction

	mode_t       mode_q, mode_d;
	logic [7:0]  delim_q, delim_d;
	logic [11:0] acc_q, acc_d;
	logic        acc;
	logic [4:0]  hv;

	assign in_ready = !full;
	assign acc      = in_valid && in_ready;
	assign hv       = end_of_input ? 5'h10 : hex_val(char_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			delim_q <= '0;
			acc_q   <= '0;
		end else begin
			mode_q  <= mode_d;
			delim_q <= delim_d;
			acc_q   <= acc_d;
		end
	end

	always_comb begin
		mode_d     = mode_q;
		delim_d    = delim_q;
		acc_d      = acc_q;
		push       = 1'b0;
		cmd.kind   = CMD_BYTE;
		cmd.val    = {8'h00, char_byte};
		cmd.status = ST_OK;
		if (acc) begin
			unique case (mode_q)
				MODE_IDLE: begin
					if (!end_of_input) begin
						delim_d = char_byte;
						acc_d   = '0;
						mode_d  = MODE_BODY;
					end
				end
				MODE_BODY: begin
					push = 1'b1;
					if (end_of_input) begin
						cmd.kind   = CMD_END;
						cmd.status = ST_UNTERM;
						mode_d     = MODE_IDLE;
					end else if (char_byte == delim_q) begin
						cmd.kind = CMD_END;
						mode_d   = MODE_IDLE;
					end else if (char_byte == CH_NL) begin
						cmd.kind   = CMD_END;
						cmd.status = ST_UNTERM;
						mode_d     = MODE_IDLE;
					end else if (char_byte == CH_BSL) begin
						push   = 1'b0;
						mode_d = MODE_ESC;
					end
				end
				MODE_ESC: begin
					push   = 1'b1;
					mode_d = MODE_BODY;
					if (end_of_input) begin
						cmd.kind   = CMD_END;
						cmd.status = ST_BAD_ESC;
						mode_d     = MODE_IDLE;
					end else begin
						unique case (char_byte)
							CH_NUL, CH_DQ, CH_BSL, CH_SL: cmd.val = {8'h00, char_byte};
							CH_B:  cmd.val = 16'h0008;
							CH_F:  cmd.val = 16'h000C;
							CH_N:  cmd.val = 16'h000A;
							CH_R:  cmd.val = 16'h000D;
							CH_T:  cmd.val = 16'h0009;
							CH_U: begin
								push   = 1'b0;
								acc_d  = '0;
								mode_d = MODE_HEX1;
							end
							default: begin
								cmd.kind   = CMD_END;
								cmd.status = ST_BAD_ESC;
								mode_d     = MODE_IDLE;
							end
						endcase
					end
				end
				MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
					if (hv[4]) begin
						push       = 1'b1;
						cmd.kind   = CMD_END;
						cmd.status = ST_BAD_HEX;
						acc_d      = '0;
						mode_d     = MODE_IDLE;
					end else if (mode_q == MODE_HEX4) begin
						push     = 1'b1;
						cmd.kind = CMD_CP;
						cmd.val  = {acc_q, hv[3:0]};
						acc_d    = '0;
						mode_d   = MODE_BODY;
					end else begin
						acc_d  = {acc_q[7:0], hv[3:0]};
						mode_d = mode_t'(mode_q + 3'd1);
					end
				end
				default: mode_d = MODE_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/slu_queue.sv =====
module slu_queue
	import slu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output cmd_t rdata,
	output logic empty
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/slu_back.sv =====
module slu_back
	import slu_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  cmd_t             head,
	output logic             pop,
	input  logic [LEN_W-1:0] max_length,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       data_byte,
	output logic             is_data,
	output logic             last,
	output logic [2:0]       status,
	output logic [LEN_W-1:0] content_length
);

	localparam int EXT_W = LENGTH_BITS + LEN_W;

	logic                   valid_q;
	logic [7:0]             data_q;
	logic                   isd_q;
	logic                   last_q;
	status_t                status_q;
	logic [LEN_W-1:0]       len_q;
	logic [1:0]             sub_q;
	logic [LENGTH_BITS-1:0] cnt_q;

	logic             load;
	logic             issue;
	logic             sub_last;
	logic [7:0]       byte_n;
	logic [15:0]      cp;
	logic [EXT_W-1:0] cnt_ext;
	logic [EXT_W-1:0] max_ext;
	status_t          end_status;

	assign cp         = head.val;
	assign load       = !valid_q || out_ready;
	assign issue      = load && !empty;
	assign pop        = issue && sub_last;
	assign cnt_ext    = {{LEN_W{1'b0}}, cnt_q};
	assign max_ext    = {{LENGTH_BITS{1'b0}}, max_length};
	assign end_status = (head.status == ST_OK && cnt_ext >= max_ext) ? ST_TOO_LONG
	                                                                 : head.status;

	always_comb begin
		byte_n   = cp[7:0];
		sub_last = 1'b1;
		if (head.kind == CMD_CP) begin
			if (cp < UTF8_1B_LIMIT) begin
				byte_n = cp[7:0];
			end else if (cp < UTF8_2B_LIMIT) begin
				sub_last = sub_q == 2'd1;
				byte_n   = (sub_q == 2'd0) ? (UTF8_LEAD2 | {3'b000, cp[10:6]})
				                           : (UTF8_CONT | (cp[7:0] & UTF8_CONT_MSK));
			end else begin
				sub_last = sub_q == 2'd2;
				unique case (sub_q)
					2'd0:    byte_n = UTF8_LEAD3 | {4'h0, cp[15:12]};
					2'd1:    byte_n = UTF8_CONT | {2'b00, cp[11:6]};
					default: byte_n = UTF8_CONT | (cp[7:0] & UTF8_CONT_MSK);
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= '0;
			cnt_q   <= '0;
		end else if (load) begin
			valid_q <= !empty;
			if (issue) begin
				sub_q <= sub_last ? 2'd0 : sub_q + 2'd1;
				if (head.kind == CMD_END)
					cnt_q <= '0;
				else if (cnt_q != {LENGTH_BITS{1'b1}})
					cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			if (head.kind == CMD_END) begin
				data_q   <= '0;
				isd_q    <= 1'b0;
				last_q   <= 1'b1;
				status_q <= end_status;
				len_q    <= cnt_ext[LEN_W-1:0];
			end else begin
				data_q   <= byte_n;
				isd_q    <= 1'b1;
				last_q   <= 1'b0;
				status_q <= ST_OK;
				len_q    <= '0;
			end
		end
	end

	assign out_valid      = valid_q;
	assign data_byte      = data_q;
	assign is_data        = isd_q;
	assign last           = last_q;
	assign status         = status_q;
	assign content_length = len_q;

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !isd_q |-> last_q)
		else $error("non-data transaction without last");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && isd_q |-> status_q == ST_OK && len_q == '0)
		else $error("data transaction carries status or length");

	a_sub_in_cp: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q != 2'd0 |-> !empty && head.kind == CMD_CP)
		else $error("multi-byte position outside a code point");

	a_cnt_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		issue && head.kind == CMD_END |=> cnt_q == '0)
		else $error("byte count not cleared after end of literal");

endmodule
